// ===== sv/sbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants of the symbol boundary locator: request kinds,
// field widths and the records that pass between the table modules and the
// controller.
// ----------------------------------------------------------------------------
package sbl_pkg;

  // Width of addresses, sizes and offsets.
  localparam int DATA_W = 64;
  // Width of the reported symbol index (load order index, low bits).
  localparam int IDX_W = 12;
  // Width of the request kind.
  localparam int REQ_W = 2;

  // Request kinds carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND_SEG = 2'd1;
  localparam logic [REQ_W-1:0] REQ_APPEND_SYM = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd3;

  // One segment table entry.
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] mem_size;
    logic [DATA_W-1:0] file_size;
    logic [DATA_W-1:0] offset;
  } seg_entry_t;

  // What the segment table reports about the entry read in the last cycle.
  typedef struct packed {
    logic              win_hit;    // query address inside, end exclusive
    logic              lo_hit;     // lower bound inside, end inclusive
    logic              hi_hit;     // upper bound inside, end inclusive
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] win_end;    // base plus file size
    logic [DATA_W-1:0] lo_into;    // lower bound minus base
    logic [DATA_W-1:0] hi_into;    // upper bound minus base
    logic [DATA_W-1:0] file_size;
    logic [DATA_W-1:0] offset;
  } seg_rsp_t;

  // One symbol table entry.
  typedef struct packed {
    logic              usable;
    logic [DATA_W-1:0] addr;
  } sym_entry_t;

  // What the symbol table reports about the entry read in the last cycle.
  typedef struct packed {
    logic              lo_hit;     // becomes the new lower bound
    logic              hi_hit;     // becomes the new upper bound
    logic [DATA_W-1:0] addr;
  } sym_rsp_t;

endpackage

// ===== sv/symbol_boundary_locator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_boundary_locator_unit
// Segment and symbol tables with a query sequencer that finds the nearest
// usable symbols below and above an address, with their file offsets.
//
// Channel  Dir  Width  Contents
// s_axis   in   264+2  request: tdata fields, tuser request kind
// m_axis   out  416    query result, one transaction per query
//
// Clear and append requests may follow back to back.
// During a query the symbol memory's single read port is swept one entry
// per cycle, and the segment memory is swept once for the window and once
// for the two file offsets. The input is held off while a query runs and
// while its result waits for the output register to free up.
// A query result may wait on m_axis while further requests are accepted.
// Reset clears both counts; table contents need no clearing pass.
// ----------------------------------------------------------------------------
module symbol_boundary_locator_unit #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_SYMBOLS  = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // addr[63:0], seg_mem_size[127:64], seg_file_size[191:128],
  // seg_file_offset[255:192], sym_defined[256], sym_named[257], zero[263:258]
  input  logic [263:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // below_found[0], below_index[12:1], below_addr[76:13],
  // below_distance[140:77], below_file_offset[204:141], above_found[205],
  // above_index[217:206], above_addr[281:218], above_distance[345:282],
  // above_file_offset[409:346], zero[415:410]
  output logic [415:0] m_axis_tdata
);
  import sbl_pkg::*;

  localparam int SEG_IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SYM_IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SYM_CW = $clog2(MAX_SYMBOLS + 1);
  localparam int CNT_W  = (SEG_CW > SYM_CW) ? SEG_CW : SYM_CW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WIN  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_OFF  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state;
  logic [SEG_CW-1:0] seg_count;
  logic [SYM_CW-1:0] sym_count;
  logic [CNT_W-1:0]  sweep_idx;
  logic [CNT_W-1:0]  sweep_limit;
  logic              rd_pend;
  logic              issue;
  logic              sweep_end;
  logic              win_done;
  logic              sweep_restart;
  logic              s_acc;
  logic              out_load;

  logic [REQ_W-1:0]  req;
  logic [DATA_W-1:0] in_addr;
  logic              in_defined;
  logic              in_named;

  logic [DATA_W-1:0] q_addr;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] hi;
  logic              lo_found;
  logic              hi_found;
  logic [SYM_IW-1:0] lo_idx;
  logic [SYM_IW-1:0] hi_idx;
  logic [SYM_IW-1:0] sym_idx_q;
  logic              lo_off_hit;
  logic              hi_off_hit;
  logic [DATA_W-1:0] lo_fs;
  logic [DATA_W-1:0] lo_into;
  logic [DATA_W-1:0] lo_off;
  logic [DATA_W-1:0] hi_fs;
  logic [DATA_W-1:0] hi_into;
  logic [DATA_W-1:0] hi_off;
  logic [DATA_W-1:0] lo_fo;
  logic [DATA_W-1:0] hi_fo;
  logic [SYM_IW+IDX_W-1:0] lo_idx_ext;
  logic [SYM_IW+IDX_W-1:0] hi_idx_ext;

  logic              seg_wr;
  logic              sym_wr;
  seg_entry_t        seg_wr_entry;
  sym_entry_t        sym_wr_entry;
  seg_rsp_t          seg_rsp;
  sym_rsp_t          sym_rsp;

  // Input field extraction.
  assign req        = s_axis_tuser;
  assign in_addr    = s_axis_tdata[63:0];
  assign in_defined = s_axis_tdata[256];
  assign in_named   = s_axis_tdata[257];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Table writes on append transactions that still fit.
  assign seg_wr = s_acc && (req == REQ_APPEND_SEG) && (seg_count < SEG_CW'(MAX_SEGMENTS));
  assign sym_wr = s_acc && (req == REQ_APPEND_SYM) && (sym_count < SYM_CW'(MAX_SYMBOLS));

  assign seg_wr_entry.base      = in_addr;
  assign seg_wr_entry.mem_size  = s_axis_tdata[127:64];
  assign seg_wr_entry.file_size = s_axis_tdata[191:128];
  assign seg_wr_entry.offset    = s_axis_tdata[255:192];
  assign sym_wr_entry.addr      = in_addr;
  assign sym_wr_entry.usable    = in_defined && in_named && (in_addr != '0);

  // Sweep over the table that the current state walks, one read per cycle.
  always_comb begin
    sweep_limit   = (state == ST_SCAN) ? CNT_W'(sym_count) : CNT_W'(seg_count);
    issue         = ((state == ST_WIN) || (state == ST_SCAN) || (state == ST_OFF)) &&
                    (sweep_idx < sweep_limit);
    sweep_end     = (sweep_idx == sweep_limit) && !rd_pend;
    // The first segment holding the query ends the window search.
    win_done      = (state == ST_WIN) && ((rd_pend && seg_rsp.win_hit) || sweep_end);
    sweep_restart = (s_acc && (req == REQ_QUERY)) || win_done ||
                    ((state == ST_SCAN) && sweep_end);
  end

  sbl_seg_table #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .SEG_IW      (SEG_IW)
  ) u_seg (
    .clk       (clk),
    .wr_en     (seg_wr),
    .wr_idx    (seg_count[SEG_IW-1:0]),
    .wr_entry  (seg_wr_entry),
    .rd_en     (issue && (state != ST_SCAN)),
    .rd_idx    (sweep_idx[SEG_IW-1:0]),
    .query_addr(q_addr),
    .lo_addr   (lo),
    .hi_addr   (hi),
    .rsp       (seg_rsp)
  );

  sbl_sym_table #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .SYM_IW     (SYM_IW)
  ) u_sym (
    .clk       (clk),
    .wr_en     (sym_wr),
    .wr_idx    (sym_count[SYM_IW-1:0]),
    .wr_entry  (sym_wr_entry),
    .rd_en     (issue && (state == ST_SCAN)),
    .rd_idx    (sweep_idx[SYM_IW-1:0]),
    .query_addr(q_addr),
    .lo_addr   (lo),
    .hi_addr   (hi),
    .rsp       (sym_rsp)
  );

  // Control: sequencer, counts, sweep counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seg_count     <= '0;
      sym_count     <= '0;
      sweep_idx     <= '0;
      rd_pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_pend <= issue && !win_done;
      if (sweep_restart) begin
        sweep_idx <= '0;
      end else if (issue) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (req)
              REQ_CLEAR: begin
                seg_count <= '0;
                sym_count <= '0;
              end
              REQ_APPEND_SEG: begin
                if (seg_wr) begin
                  seg_count <= seg_count + 1'b1;
                end
              end
              REQ_APPEND_SYM: begin
                if (sym_wr) begin
                  sym_count <= sym_count + 1'b1;
                end
              end
              REQ_QUERY: begin
                state <= ST_WIN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WIN: begin
          if (win_done) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sweep_end) begin
            state <= ST_OFF;
          end
        end
        ST_OFF: begin
          if (sweep_end) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Bounds and file offset captures for the query in progress.
  always_ff @(posedge clk) begin
    if (issue) begin
      sym_idx_q <= sweep_idx[SYM_IW-1:0];
    end
    if (s_acc && (req == REQ_QUERY)) begin
      q_addr     <= in_addr;
      lo         <= '0;
      hi         <= '1;
      lo_found   <= 1'b0;
      hi_found   <= 1'b0;
      lo_idx     <= '0;
      hi_idx     <= '0;
      lo_off_hit <= 1'b0;
      hi_off_hit <= 1'b0;
      lo_fs      <= '0;
      lo_into    <= '0;
      lo_off     <= '0;
      hi_fs      <= '0;
      hi_into    <= '0;
      hi_off     <= '0;
    end
    // Window from the segment holding the query.
    if ((state == ST_WIN) && rd_pend && seg_rsp.win_hit) begin
      lo <= seg_rsp.base;
      hi <= seg_rsp.win_end;
    end
    // Symbol scan; later symbols win ties.
    if ((state == ST_SCAN) && rd_pend) begin
      if (sym_rsp.lo_hit) begin
        lo       <= sym_rsp.addr;
        lo_found <= 1'b1;
        lo_idx   <= sym_idx_q;
      end
      if (sym_rsp.hi_hit) begin
        hi       <= sym_rsp.addr;
        hi_found <= 1'b1;
        hi_idx   <= sym_idx_q;
      end
    end
    // First segment holding each bound gives its file offset.
    if ((state == ST_OFF) && rd_pend) begin
      if (seg_rsp.lo_hit && !lo_off_hit) begin
        lo_off_hit <= 1'b1;
        lo_fs      <= seg_rsp.file_size;
        lo_into    <= seg_rsp.lo_into;
        lo_off     <= seg_rsp.offset;
      end
      if (seg_rsp.hi_hit && !hi_off_hit) begin
        hi_off_hit <= 1'b1;
        hi_fs      <= seg_rsp.file_size;
        hi_into    <= seg_rsp.hi_into;
        hi_off     <= seg_rsp.offset;
      end
    end
    if (out_load) begin
      m_axis_tdata <= {6'd0,
                       hi_fo, hi - q_addr, hi, hi_idx_ext[IDX_W-1:0], hi_found,
                       lo_fo, q_addr - lo, lo, lo_idx_ext[IDX_W-1:0], lo_found};
    end
  end

  // File offsets clamp the distance into the segment to its file size.
  always_comb begin
    lo_fo      = lo_off + ((lo_fs < lo_into) ? lo_fs : lo_into);
    hi_fo      = hi_off + ((hi_fs < hi_into) ? hi_fs : hi_into);
    lo_idx_ext = {{IDX_W{1'b0}}, lo_idx};
    hi_idx_ext = {{IDX_W{1'b0}}, hi_idx};
  end

  // Table counts never pass their capacity.
  a_seg_cap: assert property (@(posedge clk) disable iff (rst)
    seg_count <= SEG_CW'(MAX_SEGMENTS))
    else $error("segment count above capacity");

  a_sym_cap: assert property (@(posedge clk) disable iff (rst)
    sym_count <= SYM_CW'(MAX_SYMBOLS))
    else $error("symbol count above capacity");

  // A found lower bound never lies above the query address.
  a_lo_order: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_OUT) && lo_found) |-> (lo <= q_addr))
    else $error("lower bound above query address");

  // A found upper bound always lies above the query address.
  a_hi_order: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_OUT) && hi_found) |-> (hi > q_addr))
    else $error("upper bound not above query address");

  // A result appears only out of the result state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_OUT))
    else $error("result raised outside the result state");

endmodule

// ===== sv/sbl_seg_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_seg_table
// Segment table memory with one write and one registered read port, and the
// range checks applied to the entry just read.
// ----------------------------------------------------------------------------
module sbl_seg_table #(
  parameter int MAX_SEGMENTS = 16,
  parameter int SEG_IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [SEG_IW-1:0]         wr_idx,
  input  sbl_pkg::seg_entry_t       wr_entry,
  input  logic                      rd_en,
  input  logic [SEG_IW-1:0]         rd_idx,
  input  logic [sbl_pkg::DATA_W-1:0] query_addr,
  input  logic [sbl_pkg::DATA_W-1:0] lo_addr,
  input  logic [sbl_pkg::DATA_W-1:0] hi_addr,
  output sbl_pkg::seg_rsp_t         rsp
);
  import sbl_pkg::*;

  seg_entry_t        mem [MAX_SEGMENTS];
  seg_entry_t        rd_q;
  logic [DATA_W-1:0] seg_end;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // Range checks on the entry read in the previous cycle.
  always_comb begin
    seg_end       = rd_q.base + rd_q.mem_size;
    rsp.win_hit   = (query_addr >= rd_q.base) && (query_addr < seg_end);
    rsp.lo_hit    = (lo_addr >= rd_q.base) && (lo_addr <= seg_end);
    rsp.hi_hit    = (hi_addr >= rd_q.base) && (hi_addr <= seg_end);
    rsp.base      = rd_q.base;
    rsp.win_end   = rd_q.base + rd_q.file_size;
    rsp.lo_into   = lo_addr - rd_q.base;
    rsp.hi_into   = hi_addr - rd_q.base;
    rsp.file_size = rd_q.file_size;
    rsp.offset    = rd_q.offset;
  end

endmodule

// ===== sv/sbl_sym_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_sym_table
// Symbol table memory with one write and one registered read port, and the
// bound comparisons applied to the symbol just read.
// ----------------------------------------------------------------------------
module sbl_sym_table #(
  parameter int MAX_SYMBOLS = 4096,
  parameter int SYM_IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [SYM_IW-1:0]          wr_idx,
  input  sbl_pkg::sym_entry_t        wr_entry,
  input  logic                       rd_en,
  input  logic [SYM_IW-1:0]          rd_idx,
  input  logic [sbl_pkg::DATA_W-1:0] query_addr,
  input  logic [sbl_pkg::DATA_W-1:0] lo_addr,
  input  logic [sbl_pkg::DATA_W-1:0] hi_addr,
  output sbl_pkg::sym_rsp_t          rsp
);
  import sbl_pkg::*;

  sym_entry_t mem [MAX_SYMBOLS];
  sym_entry_t rd_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // A usable symbol tightens whichever bound it falls inside.
  always_comb begin
    rsp.addr   = rd_q.addr;
    rsp.lo_hit = rd_q.usable && (rd_q.addr <= query_addr) && (rd_q.addr >= lo_addr);
    rsp.hi_hit = rd_q.usable && (rd_q.addr > query_addr) && (rd_q.addr <= hi_addr);
  end

endmodule

// ===== verif/symbol_boundary_locator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_boundary_locator_unit_test
// Self-checking bench for the symbol boundary locator. Requests enter on
// s_axis and are mirrored into a bench-side copy of the segment and symbol
// tables. Each accepted query gets its nearest-symbol bounds computed here
// and queued. Each result on m_axis is compared field by field with the
// oldest queued bounds. Directed cases cover empty tables, window edges,
// skipped symbols, a full segment table and densely packed symbols. Random
// episodes follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module symbol_boundary_locator_unit_test;
  import sbl_pkg::*;

  localparam int SEG_DEPTH   = 16;
  localparam int SYM_DEPTH   = 4096;
  localparam int CYCLE_LIMIT = 2000000;

  // One request as it travels on s_axis.
  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] mem_size;
    logic [DATA_W-1:0] file_size;
    logic [DATA_W-1:0] file_offset;
    logic              defined;
    logic              named;
  } request_t;

  // The bounds that one query reports.
  typedef struct packed {
    logic              below_found;
    logic [IDX_W-1:0]  below_index;
    logic [DATA_W-1:0] below_addr;
    logic [DATA_W-1:0] below_distance;
    logic [DATA_W-1:0] below_file_offset;
    logic              above_found;
    logic [IDX_W-1:0]  above_index;
    logic [DATA_W-1:0] above_addr;
    logic [DATA_W-1:0] above_distance;
    logic [DATA_W-1:0] above_file_offset;
  } bounds_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [263:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [415:0] m_axis_tdata;

  // Bench copy of the tables.
  seg_entry_t        seg_tab [SEG_DEPTH];
  int                seg_count;
  logic [DATA_W-1:0] sym_addr [SYM_DEPTH];
  logic              sym_ok [SYM_DEPTH];
  int                sym_count;

  bounds_t expected_bounds[$];
  int      mismatch_count = 0;
  int      items_sent;
  int      cycle_count;
  bit      gaps_on;
  bit      drain_mode;

  symbol_boundary_locator_unit #(
    .MAX_SEGMENTS(SEG_DEPTH),
    .MAX_SYMBOLS (SYM_DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock, 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // File offset of an address: first segment holding it, end inclusive.
  function automatic logic [63:0] file_offset_at(logic [63:0] v);
    logic [63:0] into;
    logic [63:0] result;
    bit          hit;
    result = '0;
    hit    = 1'b0;
    for (int i = 0; i < seg_count && !hit; i++) begin
      if (v >= seg_tab[i].base && v <= seg_tab[i].base + seg_tab[i].mem_size) begin
        into   = v - seg_tab[i].base;
        result = seg_tab[i].offset +
                 ((seg_tab[i].file_size < into) ? seg_tab[i].file_size : into);
        hit    = 1'b1;
      end
    end
    return result;
  endfunction

  // Nearest usable symbols around a query address within its window.
  function automatic bounds_t locate_bounds(logic [63:0] q);
    bounds_t     r;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          in_window;
    r         = '0;
    lo        = '0;
    hi        = '1;
    in_window = 1'b0;
    for (int i = 0; i < seg_count && !in_window; i++) begin
      if (q >= seg_tab[i].base && q < seg_tab[i].base + seg_tab[i].mem_size) begin
        lo        = seg_tab[i].base;
        hi        = seg_tab[i].base + seg_tab[i].file_size;
        in_window = 1'b1;
      end
    end
    // Later symbols win ties, so the comparisons are inclusive.
    for (int i = 0; i < sym_count; i++) begin
      if (sym_ok[i]) begin
        if (sym_addr[i] <= q && sym_addr[i] >= lo) begin
          lo            = sym_addr[i];
          r.below_found = 1'b1;
          r.below_index = i[IDX_W-1:0];
        end
        if (sym_addr[i] > q && sym_addr[i] <= hi) begin
          hi            = sym_addr[i];
          r.above_found = 1'b1;
          r.above_index = i[IDX_W-1:0];
        end
      end
    end
    r.below_addr        = lo;
    r.below_distance    = q - lo;
    r.below_file_offset = file_offset_at(lo);
    r.above_addr        = hi;
    r.above_distance    = hi - q;
    r.above_file_offset = file_offset_at(hi);
    return r;
  endfunction

  // Update the bench tables for one accepted request.
  task automatic apply_request(request_t r);
    case (r.kind)
      REQ_CLEAR: begin
        seg_count = 0;
        sym_count = 0;
      end
      REQ_APPEND_SEG: begin
        if (seg_count < SEG_DEPTH) begin
          seg_tab[seg_count].base      = r.addr;
          seg_tab[seg_count].mem_size  = r.mem_size;
          seg_tab[seg_count].file_size = r.file_size;
          seg_tab[seg_count].offset    = r.file_offset;
          seg_count++;
        end
      end
      REQ_APPEND_SYM: begin
        if (sym_count < SYM_DEPTH) begin
          sym_addr[sym_count] = r.addr;
          sym_ok[sym_count]   = r.defined && r.named && (r.addr != '0);
          sym_count++;
        end
      end
      default: expected_bounds.push_back(locate_bounds(r.addr));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Drive one request and wait for its transaction.
  task automatic send_request(request_t r);
    if (!drain_mode && gaps_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 7)) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {6'b0, r.named, r.defined, r.file_offset, r.file_size,
                      r.mem_size, r.addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_request(r);
    items_sent++;
  endtask

  task automatic clear_tables();
    request_t r;
    r      = '0;
    r.kind = REQ_CLEAR;
    send_request(r);
  endtask

  task automatic append_segment(logic [63:0] base, logic [63:0] mem_size,
                                logic [63:0] file_size, logic [63:0] offset);
    request_t r;
    r             = '0;
    r.kind        = REQ_APPEND_SEG;
    r.addr        = base;
    r.mem_size    = mem_size;
    r.file_size   = file_size;
    r.file_offset = offset;
    send_request(r);
  endtask

  task automatic append_symbol(logic [63:0] addr, logic defined, logic named);
    request_t r;
    r         = '0;
    r.kind    = REQ_APPEND_SYM;
    r.addr    = addr;
    r.defined = defined;
    r.named   = named;
    send_request(r);
  endtask

  task automatic query_addr(logic [63:0] addr);
    request_t r;
    r      = '0;
    r.kind = REQ_QUERY;
    r.addr = addr;
    send_request(r);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Random stalls in bursts, with calm stretches; none while draining.
  initial begin : ready_driver
    int stall_left;
    int calm_left;
    stall_left    = 0;
    calm_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (drain_mode) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        m_axis_tready <= 1'b1;
        calm_left--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 6);
          end
          3: begin
            m_axis_tready <= 1'b1;
            calm_left = $urandom_range(20, 120);
          end
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare each result transaction with the oldest pending bounds.
  always @(posedge clk) begin : result_monitor
    bounds_t got;
    bounds_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.below_found       = m_axis_tdata[0];
      got.below_index       = m_axis_tdata[12:1];
      got.below_addr        = m_axis_tdata[76:13];
      got.below_distance    = m_axis_tdata[140:77];
      got.below_file_offset = m_axis_tdata[204:141];
      got.above_found       = m_axis_tdata[205];
      got.above_index       = m_axis_tdata[217:206];
      got.above_addr        = m_axis_tdata[281:218];
      got.above_distance    = m_axis_tdata[345:282];
      got.above_file_offset = m_axis_tdata[409:346];
      if (expected_bounds.size() == 0) begin
        report_mismatch("result with no query pending", got.below_addr, '0);
      end else begin
        want = expected_bounds.pop_front();
        check_field("below_found", got.below_found, want.below_found);
        check_field("below_index", got.below_index, want.below_index);
        check_field("below_addr", got.below_addr, want.below_addr);
        check_field("below_distance", got.below_distance, want.below_distance);
        check_field("below_file_offset", got.below_file_offset,
                    want.below_file_offset);
        check_field("above_found", got.above_found, want.above_found);
        check_field("above_index", got.above_index, want.above_index);
        check_field("above_addr", got.above_addr, want.above_addr);
        check_field("above_distance", got.above_distance, want.above_distance);
        check_field("above_file_offset", got.above_file_offset,
                    want.above_file_offset);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Queries right after reset see no segments and no symbols.
  task automatic test_empty_tables();
    query_addr('0);
    query_addr('1);
    query_addr(rand64());
  endtask

  // Window edges, overlapping segments, wrapping segment, skipped symbols
  // and ties between equal addresses.
  task automatic test_window_cases();
    clear_tables();
    append_segment(64'h4000, 64'h2000, 64'h1000, 64'h300);
    append_segment(64'h5000, 64'h4000, 64'h4000, 64'h9000);
    append_segment(64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'h800, 64'h1);
    append_symbol(64'h4100, 1'b1, 1'b1);
    append_symbol(64'h4100, 1'b1, 1'b1);
    append_symbol(64'h4200, 1'b0, 1'b1);
    append_symbol(64'h4180, 1'b1, 1'b0);
    append_symbol(64'h4300, 1'b0, 1'b0);
    append_symbol('0, 1'b1, 1'b1);
    append_symbol(64'h4800, 1'b1, 1'b1);
    append_symbol(64'h5800, 1'b1, 1'b1);
    append_symbol('1, 1'b1, 1'b1);
    query_addr(64'h4100);
    query_addr(64'h4150);
    query_addr(64'h3FFF);
    query_addr(64'h6000);
    query_addr('0);
    query_addr('1);
  endtask

  // Seventeenth and later segment appends are dropped.
  task automatic test_segment_table_full();
    clear_tables();
    for (int k = 0; k < SEG_DEPTH; k++)
      append_segment(64'h10_0000 + 64'(k) * 64'h1_0000, 64'h8000,
                     64'h800 * 64'(k + 1), 64'h100 * 64'(k));
    append_segment(64'h90_0000, 64'h8000, 64'h8000, 64'hDEAD);
    append_segment(64'h90_0000, 64'h8000, 64'h8000, 64'hBEEF);
    append_symbol(64'h10_3000, 1'b1, 1'b1);
    append_symbol(64'h1F_4000, 1'b1, 1'b1);
    append_symbol(64'h1F_8000, 1'b1, 1'b1);
    append_symbol(64'h90_1000, 1'b1, 1'b1);
    append_symbol(64'h90_3000, 1'b1, 1'b1);
    query_addr(64'h10_3100);
    query_addr(64'h1F_7FFF);
    query_addr(64'h90_2000);
    query_addr(64'h10_8000);
  endtask

  // A run of closely spaced symbols with some skipped, then two addresses between them.
  task automatic test_dense_symbols();
    gaps_on = 1'b0;
    clear_tables();
    for (int i = 0; i < 24; i++)
      append_symbol(64'h1000 + 64'(i) * 64'd16, (i % 7) != 5, 1'b1);
    append_symbol(64'h1008, 1'b1, 1'b1);
    append_symbol(64'h1058, 1'b1, 1'b1);
    query_addr(64'h1008);
    query_addr(64'h1058);
    query_addr(64'h1174);
    query_addr(64'h10);
    gaps_on = 1'b1;
  endtask

  task automatic random_segment(logic [63:0] region);
    logic [63:0] mem_size;
    logic [63:0] file_size;
    mem_size  = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 'h3000));
    file_size = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 'h3800));
    append_segment(region + 64'($urandom_range(0, 'h6000)), mem_size, file_size, rand64());
  endtask

  task automatic random_symbol(logic [63:0] region);
    logic [63:0] addr;
    case ($urandom_range(0, 9))
      0:       addr = '0;
      1:       addr = rand64();
      default: addr = region + 64'($urandom_range(0, 'h8000));
    endcase
    append_symbol(addr, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
  endtask

  // Query addresses on or next to table contents, at the extremes or at random in the region.
  function automatic logic [63:0] near_address(logic [63:0] region);
    int i;
    i = 0;
    case ($urandom_range(0, 7))
      0: if (sym_count > 0) begin
        i = $urandom_range(0, sym_count - 1);
        return sym_addr[i] + 64'($urandom_range(0, 2)) - 64'd1;
      end
      1: if (seg_count > 0) begin
        i = $urandom_range(0, seg_count - 1);
        return seg_tab[i].base;
      end
      2: if (seg_count > 0) begin
        i = $urandom_range(0, seg_count - 1);
        return seg_tab[i].base + seg_tab[i].mem_size - 64'($urandom_range(0, 1));
      end
      3: return rand64();
      4: return ($urandom_range(0, 1) == 0) ? 64'd0 : '1;
      default: ;
    endcase
    return region + 64'($urandom_range(0, 'h8000));
  endfunction

  // Any request kind with random fields.
  task automatic send_noise();
    request_t r;
    r.kind        = REQ_W'($urandom_range(0, 3));
    r.addr        = rand64();
    r.mem_size    = rand64();
    r.file_size   = rand64();
    r.file_offset = rand64();
    r.defined     = 1'($urandom_range(0, 1));
    r.named       = 1'($urandom_range(0, 1));
    send_request(r);
  endtask

  // Episodes of table building and queries around a random region.
  task automatic test_random_traffic(int n_items);
    int          start;
    int          k;
    logic [63:0] region;
    start = items_sent;
    while (items_sent - start < n_items) begin
      gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) != 0) clear_tables();
      case ($urandom_range(0, 5))
        0:       region = '0;
        1:       region = '1 - 64'hFFFF;
        default: region = rand64();
      endcase
      if ($urandom_range(0, 9) == 0)
        repeat (SEG_DEPTH + 1) random_segment(region);
      else
        repeat ($urandom_range(0, 4)) random_segment(region);
      repeat ($urandom_range(0, 20)) random_symbol(region);
      repeat ($urandom_range(2, 10)) begin
        k = $urandom_range(0, 19);
        if (k < 12)      query_addr(near_address(region));
        else if (k < 16) random_symbol(region);
        else if (k < 18) random_segment(region);
        else             send_noise();
      end
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : run
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = REQ_CLEAR;
    seg_count      = 0;
    sym_count      = 0;
    items_sent     = 0;
    gaps_on        = 1'b1;
    drain_mode     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_tables();
    test_window_cases();
    test_segment_table_full();
    test_dense_symbols();
    test_random_traffic(45);

    // Closing stretch at full rate on both sides.
    drain_mode = 1'b1;
    test_random_traffic(14);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_bounds.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
